@@ src/uhg_pkg.sv @@
// Package for the IPv4/UDP header generator: payload types, header constants
// and word index codes. No dependencies.
`default_nettype none
package uhg_pkg;

   localparam logic [15:0] VER_IHL_TOS   = 16'h4500;
   localparam logic [15:0] FLAGS_DF      = 16'h4000;
   localparam logic [7:0]  TTL_VALUE     = 8'd64;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;
   localparam logic [15:0] TTL_PROTO     = {TTL_VALUE, PROTO_UDP};
   localparam logic [15:0] IP_HDR_BYTES  = 16'd20;
   localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
   localparam logic [15:0] WORD_MASK     = 16'hFFFF;

   // seven 16-bit terms go into the raw checksum sum (the two constant
   // words pre-added as one)
   localparam int SUM_W = 19;

   localparam int QUEUE_DEPTH = 2;

   // header word positions, transmission order
   localparam logic [3:0] WORD_VER_TOS   = 4'd0;
   localparam logic [3:0] WORD_TOT_LEN   = 4'd1;
   localparam logic [3:0] WORD_IDENT     = 4'd2;
   localparam logic [3:0] WORD_FLAGS     = 4'd3;
   localparam logic [3:0] WORD_TTL_PROTO = 4'd4;
   localparam logic [3:0] WORD_IP_CSUM   = 4'd5;
   localparam logic [3:0] WORD_SRC_HI    = 4'd6;
   localparam logic [3:0] WORD_SRC_LO    = 4'd7;
   localparam logic [3:0] WORD_DST_HI    = 4'd8;
   localparam logic [3:0] WORD_DST_LO    = 4'd9;
   localparam logic [3:0] WORD_SRC_PORT  = 4'd10;
   localparam logic [3:0] WORD_DST_PORT  = 4'd11;
   localparam logic [3:0] WORD_UDP_LEN   = 4'd12;
   localparam logic [3:0] WORD_UDP_CSUM  = 4'd13;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [15:0] payload_len;
   } req_type;

   typedef struct packed {
      logic [15:0] header_word;
      logic        last;
   } rsp_type;

   // one header, fully classified, as it waits in the queue
   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [15:0] total_len;
      logic [15:0] udp_len;
      logic [15:0] checksum;
   } hdr_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage
`default_nettype wire

@@ src/uhg_front.sv @@
// Front stage: accepts requests, derives lengths and the IPv4 header checksum.
// Depends on uhg_pkg.
`default_nettype none
module uhg_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire uhg_pkg::req_type      req_data,
   input  wire uhg_pkg::q_status_type q_status,
   output logic                       push,
   output uhg_pkg::hdr_type           push_data
);

   logic                        valid_ff, valid_in;
   uhg_pkg::req_type            item_ff;
   logic [15:0]                 tot_len_ff, tot_len_in;
   logic [uhg_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [16:0]                 fold1;
   logic [15:0]                 fold2;
   logic                        accept;

   assign req_stall = valid_ff & q_status.full;
   assign accept    = req_valid & ~req_stall;
   assign push      = valid_ff & ~q_status.full;

   always_comb begin
      tot_len_in = req_data.payload_len + uhg_pkg::IP_HDR_BYTES + uhg_pkg::UDP_HDR_BYTES;
      sum_in = uhg_pkg::SUM_W'(uhg_pkg::VER_IHL_TOS + uhg_pkg::FLAGS_DF)
             + uhg_pkg::SUM_W'(uhg_pkg::TTL_PROTO)
             + uhg_pkg::SUM_W'(tot_len_in)
             + uhg_pkg::SUM_W'(req_data.src_addr[31:16])
             + uhg_pkg::SUM_W'(req_data.src_addr[15:0])
             + uhg_pkg::SUM_W'(req_data.dst_addr[31:16])
             + uhg_pkg::SUM_W'(req_data.dst_addr[15:0]);
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff    <= req_data;
         tot_len_ff <= tot_len_in;
         sum_ff     <= sum_in;
      end
   end

   // two end-around folds settle a 19-bit sum
   always_comb begin
      fold1 = 17'(sum_ff[15:0]) + 17'(sum_ff[uhg_pkg::SUM_W-1:16]);
      fold2 = fold1[15:0] + 16'(fold1[16]);
   end

   always_comb begin
      push_data.src_addr  = item_ff.src_addr;
      push_data.dst_addr  = item_ff.dst_addr;
      push_data.src_port  = item_ff.src_port;
      push_data.dst_port  = item_ff.dst_port;
      push_data.total_len = tot_len_ff;
      push_data.udp_len   = item_ff.payload_len + uhg_pkg::UDP_HDR_BYTES;
      push_data.checksum  = fold2 ^ uhg_pkg::WORD_MASK;
   end

endmodule
`default_nettype wire

@@ src/uhg_queue.sv @@
// Short FIFO of classified headers between the front and back stages.
// Depends on uhg_pkg.
`default_nettype none
module uhg_queue #(
   parameter int DEPTH = uhg_pkg::QUEUE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire uhg_pkg::hdr_type      push_data,
   input  wire logic                  pop,
   output uhg_pkg::hdr_type           head_data,
   output uhg_pkg::q_status_type      q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   uhg_pkg::hdr_type  entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign q_status.full  = (count_ff == FULL_CNT);
   assign q_status.empty = (count_ff == '0);
   assign do_push   = push & ~q_status.full;
   assign do_pop    = pop & ~q_status.empty;
   assign head_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ src/uhg_back.sv @@
// Back stage: serializes one queued header into fourteen words on the result
// channel through an output register. Depends on uhg_pkg.
`default_nettype none
module uhg_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire uhg_pkg::q_status_type q_status,
   input  wire uhg_pkg::hdr_type      head_data,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output uhg_pkg::rsp_type           rsp_data
);

   logic              busy_ff, busy_in;
   logic [3:0]        idx_ff, idx_in;
   uhg_pkg::hdr_type  cur_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   uhg_pkg::rsp_type  rsp_ff, rsp_in;
   logic              advance, finish;

   assign advance = busy_ff & (~rsp_valid_ff | ~rsp_stall);
   assign finish  = advance & (idx_ff == uhg_pkg::WORD_UDP_CSUM);
   assign pop     = ~q_status.empty & (~busy_ff | finish);

   always_comb begin
      unique case (idx_ff)
         uhg_pkg::WORD_VER_TOS:   rsp_in.header_word = uhg_pkg::VER_IHL_TOS;
         uhg_pkg::WORD_TOT_LEN:   rsp_in.header_word = cur_ff.total_len;
         uhg_pkg::WORD_IDENT:     rsp_in.header_word = 16'h0000;
         uhg_pkg::WORD_FLAGS:     rsp_in.header_word = uhg_pkg::FLAGS_DF;
         uhg_pkg::WORD_TTL_PROTO: rsp_in.header_word = uhg_pkg::TTL_PROTO;
         uhg_pkg::WORD_IP_CSUM:   rsp_in.header_word = cur_ff.checksum;
         uhg_pkg::WORD_SRC_HI:    rsp_in.header_word = cur_ff.src_addr[31:16];
         uhg_pkg::WORD_SRC_LO:    rsp_in.header_word = cur_ff.src_addr[15:0];
         uhg_pkg::WORD_DST_HI:    rsp_in.header_word = cur_ff.dst_addr[31:16];
         uhg_pkg::WORD_DST_LO:    rsp_in.header_word = cur_ff.dst_addr[15:0];
         uhg_pkg::WORD_SRC_PORT:  rsp_in.header_word = cur_ff.src_port;
         uhg_pkg::WORD_DST_PORT:  rsp_in.header_word = cur_ff.dst_port;
         uhg_pkg::WORD_UDP_LEN:   rsp_in.header_word = cur_ff.udp_len;
         uhg_pkg::WORD_UDP_CSUM:  rsp_in.header_word = 16'h0000;
         default:                 rsp_in.header_word = 16'h0000;
      endcase
      rsp_in.last = (idx_ff == uhg_pkg::WORD_UDP_CSUM);
   end

   always_comb begin
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = uhg_pkg::WORD_VER_TOS;
      end else if (finish) begin
         busy_in = 1'b0;
         idx_in  = uhg_pkg::WORD_VER_TOS;
      end else if (advance) begin
         busy_in = 1'b1;
         idx_in  = idx_ff + 4'd1;
      end else begin
         busy_in = busy_ff;
         idx_in  = idx_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= uhg_pkg::WORD_VER_TOS;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

@@ src/ipv4_udp_header_generator.sv @@
// Top level of the IPv4/UDP header generator: front stage, header queue and
// back stage. Depends on uhg_pkg, uhg_front, uhg_queue and uhg_back.
//
// Each request item (addresses, ports, payload length) yields fourteen
// big-endian 16-bit result items: the 20-byte IPv4 header (version 4, IHL 5,
// DF set, TTL 64, protocol UDP, RFC 1071 header checksum) followed by the
// 8-byte UDP header with a zero checksum; last marks the fourteenth word.
// Sustained rate is set by the one-word result channel that the back stage's
// word counter drives. A request's first word passes through the front
// register, the queue, the back stage's header register and the output
// register on its way to the result port. Up to QUEUE_DEPTH classified
// headers, plus one in the front register, are buffered, so new requests are
// taken while earlier headers are still being sent. Total and UDP lengths wrap
// modulo 65536 for oversized payloads; a folded sum of all ones gives 0x0000.
`default_nettype none
module ipv4_udp_header_generator #(
   parameter int QUEUE_DEPTH = uhg_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire uhg_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output uhg_pkg::rsp_type      rsp_data
);

   uhg_pkg::q_status_type q_status;
   logic                  push, pop;
   uhg_pkg::hdr_type      push_data, head_data;

   // front: accept, lengths, checksum
   uhg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   // decouples acceptance from serialization
   uhg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .q_status  (q_status)
   );

   // back: one header word per cycle into the output register, unless the result channel stalls
   uhg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_data (head_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

@@ verif/tb_ipv4_udp_header_generator.sv @@
// Testbench for ipv4_udp_header_generator: every request is checked against a
// header built here, word by word. Depends on uhg_pkg and the RTL top level.
`timescale 1ns / 100ps
module tb_ipv4_udp_header_generator;
   import uhg_pkg::*;

   localparam int RANDOM_ITEMS = 410;
   localparam int MAX_REPORTS  = 10;
   localparam int IDLE_LIMIT   = 3000;  // cycles with no handshake on either side
   localparam int HOLD_AT      = 120;   // requests taken before the long rsp hold-off
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int HDR_WORDS    = 14;

   // Keeps the header words still owed by the block, oldest first.
   class header_scoreboard;
      rsp_type     expected_words[$];
      int unsigned mismatches;
      int unsigned words_seen;

      // Builds the fourteen header words for one accepted request.
      function void note_request(req_type r);
         logic [15:0] w [HDR_WORDS];
         logic [19:0] csum;
         rsp_type     word;
         w[WORD_VER_TOS]   = VER_IHL_TOS;
         w[WORD_TOT_LEN]   = r.payload_len + UDP_HDR_BYTES + IP_HDR_BYTES;
         w[WORD_IDENT]     = 16'h0000;
         w[WORD_FLAGS]     = FLAGS_DF;
         w[WORD_TTL_PROTO] = TTL_PROTO;
         w[WORD_IP_CSUM]   = 16'h0000;
         w[WORD_SRC_HI]    = r.src_addr[31:16];
         w[WORD_SRC_LO]    = r.src_addr[15:0];
         w[WORD_DST_HI]    = r.dst_addr[31:16];
         w[WORD_DST_LO]    = r.dst_addr[15:0];
         w[WORD_SRC_PORT]  = r.src_port;
         w[WORD_DST_PORT]  = r.dst_port;
         w[WORD_UDP_LEN]   = r.payload_len + UDP_HDR_BYTES;
         w[WORD_UDP_CSUM]  = 16'h0000;
         // ones' complement sum over the IPv4 words, checksum slot taken as zero
         csum = '0;
         for (int i = 0; i <= WORD_DST_LO; i++)
            csum += {4'h0, w[i]};
         while (csum[19:16] != 4'h0)
            csum = {4'h0, csum[15:0]} + {16'h0000, csum[19:16]};
         // all-ones sum gives 0x0000, no substitution
         w[WORD_IP_CSUM] = ~csum[15:0];
         for (int i = 0; i < HDR_WORDS; i++) begin
            word.header_word = w[i];
            word.last        = (i == WORD_UDP_CSUM);
            expected_words.push_back(word);
         end
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         words_seen++;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected word %h last %b", $time, got.header_word, got.last);
            return;
         end
         want = expected_words.pop_front();
         if (got.header_word !== want.header_word || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: word %0d: expected %h last %b, got %h last %b", $time,
                        (words_seen - 1) % HDR_WORDS, want.header_word, want.last,
                        got.header_word, got.last);
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   header_scoreboard sb = new();
   int unsigned      requests_taken = 0;
   int unsigned      idle_cycles = 0;

   always #6 clock = ~clock;

   ipv4_udp_header_generator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Monitor and watchdog: sample both handshakes on the pre-edge values.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_request(req_data);
            requests_taken++;
         end
         if (rsp_valid && !rsp_stall)
            sb.check_word(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_ipv4_udp_header_generator: FAIL");
            $finish;
         end
      end
   end

   // Offer one item and hold it until taken. Valid stays high on return so a
   // following item goes out back to back.
   task automatic send_request(input req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic sender_gap(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_all_words();
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // Mostly legal lengths, small ones weighted, with some oversized ones that
   // wrap the length fields.
   function automatic req_type random_request();
      req_type r;
      r.src_addr = $urandom;
      r.dst_addr = $urandom;
      r.src_port = 16'($urandom);
      r.dst_port = 16'($urandom);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: r.payload_len = 16'($urandom_range(0, 1472));
         4, 5, 6:    r.payload_len = 16'($urandom_range(0, 65507));
         7:          r.payload_len = 16'($urandom_range(65400, 65507));
         8:          r.payload_len = 16'($urandom_range(65508, 65535));
         default: begin
            r.payload_len = 16'($urandom_range(0, 64));
            // corner address halves push the checksum fold around
            if ($urandom_range(0, 1)) r.src_addr = 32'hFFFF_FFFF;
            if ($urandom_range(0, 1)) r.dst_addr = 32'h0000_0000;
         end
      endcase
      return r;
   endfunction

   // Receiver: stretches of no stall, light or heavy random stall, or a fixed
   // period; one long hold-off once traffic is going so the block backs up.
   initial begin
      int mode;
      int span;
      int period;
      int phase;
      bit hold_done;
      span = 0;
      period = 1;
      phase = 0;
      hold_done = 1'b0;
      mode = 0;
      @(posedge clock);
      forever begin
         if (!hold_done && requests_taken >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (span == 0) begin
            mode   = $urandom_range(0, 3);
            span   = $urandom_range(10, 150);
            period = $urandom_range(2, 9);
            phase  = 0;
         end
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 25);
            2: rsp_stall <= ($urandom_range(0, 99) < 75);
            default: rsp_stall <= (phase == 0);
         endcase
         phase = (phase + 1) % period;
         span--;
         @(posedge clock);
      end
   end

   // Stimulus
   initial begin
      int sent;
      int burst;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, wrapped lengths, all-ones checksum sum.
      send_request('{32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000, 16'd0});
      send_request('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      send_request('{32'hC0A8_0001, 32'hC0A8_00FE, 16'd1234, 16'd53, 16'd65507});
      // total length wraps to zero
      send_request('{32'h0A00_0001, 32'h0A00_0002, 16'd5000, 16'd6000, 16'd65508});
      // UDP length wraps to zero
      send_request('{32'h0A00_0001, 32'h0A00_0002, 16'd7, 16'd9, 16'd65528});
      sender_gap(3);
      // folded sum of all ones, checksum word comes out zero
      send_request('{32'h0000_3AD2, 32'h0000_0000, 16'h0000, 16'h0000, 16'd0});
      send_request('{32'h0000_0000, 32'h3AD1_0000, 16'h1234, 16'h4321, 16'd1});
      send_request('{32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h5555, 16'h5555});
      send_request('{32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA, 16'h2AAA});
      sender_gap(17);
      send_request('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 16'd0});
      send_request('{32'h0000_0000, 32'h0000_0000, 16'hFFFF, 16'h0000, 16'd1472});
      send_request('{32'h8000_0001, 32'h0001_8000, 16'h8000, 16'h0001, 16'h8000});
      send_request('{32'h7FFF_FFFE, 32'hFFFE_7FFF, 16'h7FFF, 16'hFFFE, 16'h7FFF});

      // sender quiet until the block has sent everything out
      sender_gap(1);
      wait_all_words();

      // Random bursts with random gaps.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
            send_request(random_request());
            sent++;
         end
         if ($urandom_range(0, 3) != 0)
            sender_gap($urandom_range(1, 18));
      end

      // a short sender gap lets the monitor log the last request before pending is read
      sender_gap(1);
      wait_all_words();
      // extra cycles catch any stray words past the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb_ipv4_udp_header_generator: PASS");
      else
         $display("tb_ipv4_udp_header_generator: FAIL");
      $finish;
   end

endmodule
